FILE: src/cspu_pkg.sv
// shared types, constants and helpers of the can signal pack/unpack block
package cspu_pkg;

  localparam int SigWidth      = 32;
  localparam int StoreBytes    = 1024;
  localparam int MaxFrameBytes = 64;
  localparam int AddrW         = $clog2(StoreBytes);
  localparam int LenW          = 7;
  localparam int OrderW        = 3;
  localparam int SbW           = 9;
  localparam int CntW          = 6;
  localparam int PosW          = 12;
  localparam int ByteNumW      = PosW - 3;
  localparam int WinBytes      = (SigWidth + 7 + 7) / 8;
  localparam int WinW          = WinBytes * 8;
  localparam int ByteIdxW      = $clog2(WinBytes);

  typedef enum logic [OrderW-1:0] {
    FmtIntelStd = 3'd0,
    FmtIntelSeq = 3'd1,
    FmtMotLsb   = 3'd2,
    FmtMotMsb   = 3'd3,
    FmtMotSeq   = 3'd4
  } fmt_e;

  typedef enum logic {
    OpRead  = 1'b0,
    OpWrite = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StSetup,
    StRead,
    StMerge,
    StFinish
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [AddrW-1:0]    base;
    logic [LenW-1:0]     len;
    logic [OrderW-1:0]   order;
    logic [SbW-1:0]      sb;
    logic [CntW-1:0]     cnt;
    logic [SigWidth-1:0] wv;
  } req_t;

  typedef struct packed {
    logic                fmt_err;
    logic                motorola;
    logic                empty;
    logic [ByteNumW-1:0] first_byte;
    logic [2:0]          shift;
    logic [ByteIdxW-1:0] last_idx;
    logic [CntW-1:0]     cnt;
    logic [LenW-1:0]     len;
  } loc_t;

  function automatic logic [SigWidth-1:0] low_mask(input logic [CntW-1:0] cnt);
    logic [SigWidth-1:0] m;
    if (cnt >= CntW'(SigWidth)) begin
      m = '1;
    end else begin
      m = (SigWidth'(1) << cnt) - SigWidth'(1);
    end
    return m;
  endfunction

endpackage

FILE: src/can_signal_pack_unpack.sv
// top level: can signal read/write over a frame byte store with a byte sequencer
//
// input stream s_axis carries one request: tuser selects read (0) or write (1),
// tdata carries frame base, length, byte order, start bit, bit count and value.
// output stream m_axis returns one response per request: tdata is the value
// read (zero on writes), tuser flags an unknown byte order (store untouched).
// the signal spans one to five frame bytes; a single byte port of the store
// is visited once per byte: a byte outside the frame takes the read state only,
// a byte inside it a read, then a merge/write. an unknown format or zero bit
// count skips the byte visits. one request is worked on at a time; tready is
// high only while idle. after reset the store is cleared one byte per cycle,
// all 1024 bytes, with tready low. a stalled response holds in the output
// register; the next request may be accepted meanwhile but its response
// waits for the register.
module can_signal_pack_unpack (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // frame_base[9:0], frame_length[16:10], byte_order[19:17], start_bit[28:20],
  // bit_count[34:29], write_value[66:35], zero[71:67]
  input  logic [71:0] s_axis_tdata,
  // operation[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_value[31:0]
  output logic [31:0] m_axis_tdata,
  // format_error[0]
  output logic [0:0]  m_axis_tuser
);
  import cspu_pkg::*;

  localparam logic [AddrW-1:0] ClrLast = AddrW'(StoreBytes - 1);

  logic [7:0] mem [StoreBytes];

  state_e state_q, state_d;
  logic [AddrW-1:0]    clr_q;
  req_t                req_q;
  loc_t                loc_c;
  loc_t                loc_q;
  logic [ByteIdxW-1:0] j_q;
  logic [WinW-1:0]     win_q;
  logic [WinW-1:0]     wwin_q;
  logic [WinW-1:0]     wmask_q;
  logic [7:0]          rdata_q;
  logic                m_valid_q;
  logic [SigWidth-1:0] m_data_q;
  logic                m_err_q;

  logic                accept;
  logic [ByteNumW-1:0] byte_num;
  logic                in_frame;
  logic [LenW-1:0]     phys;
  logic [AddrW-1:0]    addr;
  logic                last;
  logic                advance;
  logic                mem_re;
  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  logic [7:0]          mem_wdata;
  logic [7:0]          wmask_b;
  logic [7:0]          wwin_b;
  logic                load_out;
  logic [WinW-1:0]     win_sh;
  logic [SigWidth-1:0] rv;

  cspu_locate u_locate (
    .req_i (req_q),
    .loc_o (loc_c)
  );

  assign accept = s_axis_tvalid && s_axis_tready;

  // byte address of the current window byte
  always_comb begin
    byte_num = loc_q.first_byte + ByteNumW'(j_q);
    in_frame = !byte_num[ByteNumW-1] && (byte_num < ByteNumW'(loc_q.len));
    phys     = loc_q.motorola ? (loc_q.len - LenW'(1) - byte_num[LenW-1:0])
                              : byte_num[LenW-1:0];
    addr     = req_q.base + AddrW'(phys);
    last     = (j_q == loc_q.last_idx);
    wmask_b  = wmask_q[{j_q, 3'b000} +: 8];
    wwin_b   = wwin_q[{j_q, 3'b000} +: 8];
    win_sh   = win_q >> loc_q.shift;
    rv       = (req_q.op == OpWrite) ? '0 : (win_sh[SigWidth-1:0] & low_mask(loc_q.cnt));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear:  if (clr_q == ClrLast) state_d = StIdle;
      StIdle:   if (s_axis_tvalid) state_d = StSetup;
      StSetup:  state_d = (loc_c.fmt_err || loc_c.empty) ? StFinish : StRead;
      StRead: begin
        if (in_frame) begin
          state_d = StMerge;
        end else if (last) begin
          state_d = StFinish;
        end
      end
      StMerge:  state_d = last ? StFinish : StRead;
      StFinish: if (!m_valid_q || m_axis_tready) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state_q == StIdle);
    mem_re        = (state_q == StRead) && in_frame;
    advance       = ((state_q == StRead) && !in_frame) || (state_q == StMerge);
    load_out      = (state_q == StFinish) && (!m_valid_q || m_axis_tready);
    if (state_q == StClear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = (state_q == StMerge) && (req_q.op == OpWrite);
      mem_waddr = addr;
      mem_wdata = (rdata_q & ~wmask_b) | (wwin_b & wmask_b);
    end
  end

  // byte store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.op    <= op_e'(s_axis_tuser[0]);
      req_q.base  <= s_axis_tdata[9:0];
      req_q.len   <= s_axis_tdata[16:10];
      req_q.order <= s_axis_tdata[19:17];
      req_q.sb    <= s_axis_tdata[28:20];
      req_q.cnt   <= s_axis_tdata[34:29];
      req_q.wv    <= s_axis_tdata[66:35];
    end
    if (state_q == StSetup) begin
      loc_q   <= loc_c;
      win_q   <= '0;
      wwin_q  <= WinW'(req_q.wv) << loc_c.shift;
      wmask_q <= WinW'(low_mask(loc_c.cnt)) << loc_c.shift;
    end else if ((state_q == StMerge) && (req_q.op == OpRead)) begin
      win_q[{j_q, 3'b000} +: 8] <= rdata_q;
    end
    if (load_out) begin
      m_data_q <= rv;
      m_err_q  <= loc_q.fmt_err;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_q     <= '0;
      j_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (state_q == StSetup) begin
        j_q <= '0;
      end else if (advance && !last) begin
        j_q <= j_q + ByteIdxW'(1);
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_err_q;

endmodule

FILE: src/cspu_locate.sv
// signal position decode: first frame byte, bit shift and byte span of a request
module cspu_locate (
  input  cspu_pkg::req_t req_i,
  output cspu_pkg::loc_t loc_o
);
  import cspu_pkg::*;

  logic [LenW-1:0]  len_c;
  logic [CntW-1:0]  cnt_c;
  logic [PosW-1:0]  total;
  logic [PosW-1:0]  sbs;
  logic [PosW-1:0]  sbx;
  logic [PosW-1:0]  cnts;
  logic [PosW-1:0]  p0;
  logic             err;
  logic [CntW:0]    span;

  always_comb begin
    len_c = (req_i.len > LenW'(MaxFrameBytes)) ? LenW'(MaxFrameBytes) : req_i.len;
    cnt_c = (req_i.cnt > CntW'(SigWidth)) ? CntW'(SigWidth) : req_i.cnt;
    total = PosW'({len_c, 3'b000});
    sbs   = PosW'(req_i.sb);
    sbx   = PosW'(req_i.sb ^ SbW'(7));
    cnts  = PosW'(cnt_c);
    err   = 1'b0;
    case (req_i.order)
      FmtIntelStd: p0 = sbs;
      FmtIntelSeq: p0 = sbx;
      FmtMotLsb:   p0 = total - (sbx + PosW'(1));
      FmtMotMsb:   p0 = total - (sbx + cnts);
      FmtMotSeq:   p0 = total - (sbs + cnts);
      default: begin
        p0  = '0;
        err = 1'b1;
      end
    endcase
    span = (CntW+1)'(p0[2:0]) + (CntW+1)'(cnt_c) - (CntW+1)'(1);

    loc_o.fmt_err    = err;
    loc_o.motorola   = !err && (req_i.order != FmtIntelStd) && (req_i.order != FmtIntelSeq);
    loc_o.empty      = (cnt_c == '0);
    loc_o.first_byte = p0[PosW-1:3];
    loc_o.shift      = p0[2:0];
    loc_o.last_idx   = ByteIdxW'(span >> 3);
    loc_o.cnt        = cnt_c;
    loc_o.len        = len_c;
  end

endmodule

FILE: tb/tb.sv
// testbench for can_signal_pack_unpack: random and directed signal reads/writes checked against a shadow store
module tb;
  import cspu_pkg::*;

  localparam int StallLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int NumSlots   = 6;
  localparam int SlotW      = $clog2(NumSlots);
  localparam int PhaseItems = 266;

  typedef struct packed {
    logic [SigWidth-1:0] value;
    logic                err;
  } sig_resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  logic [7:0]  frame_mem [StoreBytes];
  req_t        req_queue [$];
  sig_resp_t   resp_q [$];
  req_t        offer_req;
  sig_resp_t   want;
  int          fails = 0;
  int          tx_idle = 0;
  int          rx_stall = 0;
  logic        hold_arm = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_cnt = 0;
  int          idle_cycles = 0;
  int          slot_base [NumSlots];
  int          slot_len [NumSlots];

  can_signal_pack_unpack uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // reads or writes one signal in the shadow store, returns the response
  function automatic sig_resp_t access_frame(input req_t r);
    sig_resp_t res;
    int flen, nbits, total, p0, p, idx, addr, k, sbv;
    logic mot;
    res.value = '0;
    res.err = 1'b0;
    sbv = r.sb;
    flen = (r.len > MaxFrameBytes) ? MaxFrameBytes : int'(r.len);
    nbits = (r.cnt > SigWidth) ? SigWidth : int'(r.cnt);
    total = flen * 8;
    mot = 1'b1;
    p0 = 0;
    case (r.order)
      FmtIntelStd: begin
        p0 = sbv;
        mot = 1'b0;
      end
      FmtIntelSeq: begin
        p0 = sbv ^ 7;
        mot = 1'b0;
      end
      FmtMotLsb: p0 = total - ((sbv ^ 7) + 1);
      FmtMotMsb: p0 = total - ((sbv ^ 7) + nbits);
      FmtMotSeq: p0 = total - (sbv + nbits);
      default: begin
        res.err = 1'b1;
        return res;
      end
    endcase
    for (k = 0; k < nbits; k++) begin
      p = p0 + k;
      if (p >= 0 && p < total) begin
        idx = p >> 3;
        if (mot) begin
          idx = flen - 1 - idx;
        end
        addr = (int'(r.base) + idx) % StoreBytes;
        if (r.op == OpWrite) begin
          frame_mem[AddrW'(addr)][3'(p & 7)] = r.wv[5'(k)];
        end else begin
          res.value[5'(k)] = frame_mem[AddrW'(addr)][3'(p & 7)];
        end
      end
    end
    return res;
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        resp_q.push_back(access_frame(offer_req));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= tx_idle) begin
          offer_req = req_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'd0, offer_req.wv, offer_req.cnt, offer_req.sb,
                            offer_req.order, offer_req.len, offer_req.base};
          s_axis_tuser  <= offer_req.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and response check
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (resp_q.size() == 0) begin
          $display("%0t unexpected response: expected none, actual value %h error %b",
                   $time, m_axis_tdata, m_axis_tuser);
          fails++;
        end else begin
          want = resp_q.pop_front();
          if (m_axis_tdata !== want.value) begin
            $display("%0t read_value mismatch: expected %h actual %h",
                     $time, want.value, m_axis_tdata);
            fails++;
          end
          if (m_axis_tuser[0] !== want.err) begin
            $display("%0t format_error mismatch: expected %b actual %b",
                     $time, want.err, m_axis_tuser[0]);
            fails++;
          end
        end
      end
      if (hold_arm && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= HoldCycles;
        m_axis_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_req(input op_e op, input int base, input int len, input int order,
                         input int sb, input int cnt, input logic [31:0] wv);
    req_t r;
    r.op = op;
    r.base = AddrW'(base);
    r.len = LenW'(len);
    r.order = OrderW'(order);
    r.sb = SbW'(sb);
    r.cnt = CntW'(cnt);
    r.wv = wv;
    req_queue.push_back(r);
  endtask

  // mostly accesses to a few shared frames, the rest anywhere
  task automatic add_random_req();
    req_t r;
    int slot, pick, flen;
    slot = $urandom_range(NumSlots - 1);
    r.op = op_e'($urandom_range(1));
    r.base = AddrW'(($urandom_range(9) == 0) ? $urandom_range(StoreBytes - 1)
                                              : slot_base[SlotW'(slot)]);
    pick = $urandom_range(19);
    if (pick == 0) begin
      r.len = '0;
    end else if (pick == 1) begin
      r.len = LenW'($urandom_range(127, MaxFrameBytes + 1));
    end else begin
      r.len = LenW'(slot_len[SlotW'(slot)]);
    end
    r.order = OrderW'(($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(4));
    pick = $urandom_range(19);
    if (pick == 0) begin
      r.cnt = '0;
    end else if (pick == 1) begin
      r.cnt = CntW'($urandom_range(63, SigWidth + 1));
    end else begin
      r.cnt = CntW'($urandom_range(SigWidth, 1));
    end
    flen = (r.len > MaxFrameBytes) ? MaxFrameBytes : int'(r.len);
    if ($urandom_range(7) == 0 || flen == 0) begin
      r.sb = SbW'($urandom_range(511));
    end else begin
      r.sb = SbW'($urandom_range(flen * 8 - 1));
    end
    r.wv = $urandom;
    req_queue.push_back(r);
  endtask

  task automatic drain();
    while (req_queue.size() != 0 || s_axis_tvalid || resp_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    for (int i = 0; i < StoreBytes; i++) begin
      frame_mem[AddrW'(i)] = 8'h00;
    end
    slot_base[0] = 1020;
    slot_len[0] = 8;
    slot_base[1] = $urandom_range(StoreBytes - 1);
    slot_len[1] = MaxFrameBytes;
    for (int i = 2; i < NumSlots; i++) begin
      slot_base[SlotW'(i)] = $urandom_range(StoreBytes - 1);
      slot_len[SlotW'(i)] = $urandom_range(16, 1);
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_req(OpWrite, 0, 8, FmtIntelStd, 0, 32, 32'hffff_ffff);
    add_req(OpRead, 0, 8, FmtIntelStd, 0, 32, 32'h0);
    add_req(OpWrite, 0, 8, FmtIntelSeq, 7, 12, 32'h0000_0abc);
    add_req(OpRead, 0, 8, FmtIntelSeq, 7, 12, 32'h0);
    add_req(OpWrite, 100, 8, FmtMotLsb, 7, 16, 32'h0000_1234);
    add_req(OpRead, 100, 8, FmtMotLsb, 7, 16, 32'h0);
    add_req(OpWrite, 100, 8, FmtMotMsb, 0, 16, 32'h0000_5a5a);
    add_req(OpRead, 100, 8, FmtMotMsb, 0, 16, 32'h0);
    add_req(OpWrite, 100, 8, FmtMotSeq, 0, 20, 32'h000c_3a5f);
    add_req(OpRead, 100, 8, FmtMotSeq, 0, 20, 32'h0);
    // frame wrapping past the end of the store
    add_req(OpWrite, 1023, 64, FmtIntelStd, 4, 32, 32'hdead_beef);
    add_req(OpRead, 1023, 64, FmtIntelStd, 0, 63, 32'h0);
    // oversized frame, signal partly outside
    add_req(OpWrite, 1023, 127, FmtMotSeq, 500, 32, 32'hffff_ffff);
    add_req(OpRead, 1023, 127, FmtMotSeq, 496, 32, 32'h0);
    add_req(OpRead, 0, 0, FmtIntelStd, 0, 32, 32'h0);
    add_req(OpWrite, 0, 8, FmtIntelStd, 3, 0, 32'hffff_ffff);
    add_req(OpRead, 0, 8, FmtIntelStd, 3, 0, 32'h0);
    add_req(OpRead, 1023, 64, FmtIntelStd, 511, 32, 32'h0);
    add_req(OpWrite, 0, 8, FmtMotLsb, 511, 32, 32'hffff_ffff);
    add_req(OpRead, 0, 8, 5, 0, 32, 32'h0);
    add_req(OpWrite, 0, 8, 6, 0, 32, 32'hffff_ffff);
    add_req(OpRead, 0, 8, 7, 511, 63, 32'hffff_ffff);
    add_req(OpWrite, 0, 8, FmtIntelStd, 0, 32, 32'h0);
    add_req(OpRead, 0, 8, FmtIntelStd, 0, 32, 32'h0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      @(negedge clk_i);
      case (ph)
        1: begin
          tx_idle = 48;
          rx_stall = 0;
        end
        2: begin
          tx_idle = 0;
          rx_stall = 48;
        end
        3: begin
          tx_idle = 20;
          rx_stall = 20;
        end
        4: begin
          tx_idle = 0;
          rx_stall = 0;
          hold_arm = 1'b1;
        end
        default: begin
          tx_idle = 0;
          rx_stall = 0;
        end
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        add_random_req();
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (fails == 0 && resp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: can_signal_pack_unpack.f
src/cspu_pkg.sv
src/cspu_locate.sv
src/can_signal_pack_unpack.sv
tb/tb.sv
